>>> hdl/pnd_pkg.sv
// pnd_pkg: shared types and constants of the packed name decoder
// holds the command word passed from the front end to the back end and the alphabet map
// no dependencies
package pnd_pkg;

  localparam int CHAR_W = 7;
  localparam int CODE_W = 6;
  // wide enough for name lengths up to the largest supported NAME_MAX plus one
  localparam int LEN_W  = 9;
  localparam int QDEPTH = 4;

  localparam logic [CODE_W-1:0] CODE_END      = 6'd0;
  localparam logic [CODE_W-1:0] CODE_COPY_MIN = 6'd48;
  localparam int COPY_BIAS_LO = 56;
  localparam int COPY_BIAS_HI = 32;

  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_COPY = 2'd1;
  localparam logic [1:0] CMD_BARE = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  count;
    logic [LEN_W-1:0]  base;
    logic              last;
    logic              ovf;
  } cmd_t;

  // map a character code (1..47) to ascii
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    c = {1'b0, code};
    priority if (code >= 6'd21 && code <= 6'd46) begin
      return c + 7'h4C;
    end else if (code >= 6'd10 && code <= 6'd19) begin
      return c + 7'h26;
    end else begin
      unique case (code)
        6'd1:    return 7'h20;
        6'd2:    return 7'h23;
        6'd3:    return 7'h24;
        6'd4:    return 7'h28;
        6'd5:    return 7'h29;
        6'd6:    return 7'h2D;
        6'd7:    return 7'h2E;
        6'd8:    return 7'h2F;
        6'd9:    return 7'h3F;
        6'd20:   return 7'h5F;
        6'd47:   return 7'h7E;
        default: return 7'h00;
      endcase
    end
  endfunction

endpackage

>>> hdl/pnd_front.sv
// pnd_front: accepts table bytes, unpacks 6-bit codes and turns them into commands
// tracks name lengths so each command already carries its store position and end marking
// depends on pnd_pkg
module pnd_front #(
  parameter int NAME_MAX = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    data_byte,
  input  logic          first_of_name,
  input  logic          table_end,
  input  logic          new_archive,
  output logic          q_valid,
  input  logic          q_ready,
  output pnd_pkg::cmd_t q_cmd
);
  import pnd_pkg::*;

  localparam int CLW = $clog2(NAME_MAX + 2);
  localparam int PLW = $clog2(NAME_MAX + 1);

  logic             busy, busy_next;
  logic             load, load_next;
  logic             fin_first, fin_first_next;
  logic             active, active_next;
  logic [12:0]      bbuf, bbuf_next;
  logic [3:0]       cnt, cnt_next;
  logic             pend_v, pend_v_next;
  logic [CODE_W-1:0] pend_code, pend_code_next;
  logic [CLW-1:0]   cur_len, cur_len_next;
  logic [PLW-1:0]   prev_len, prev_len_next;
  logic             held_v, held_v_next;
  cmd_t             held, held_next;
  logic [7:0]       byte_r, byte_next;
  logic             first_r, first_next;
  logic             tend_r, tend_next;

  logic [CODE_W-1:0] code;
  logic signed [10:0] lenv;
  logic [PLW-1:0]   copy_n;
  logic [PLW-1:0]   inc;
  logic [CLW:0]     sum;
  logic             ovf_now;
  logic             finish, emit;
  cmd_t             new_cmd, bare_cmd, fin_cmd;

  assign s_tready = !busy;
  assign code     = bbuf[CODE_W-1:0];
  assign ovf_now  = (cur_len > NAME_MAX);

  // prefix length of a copy, clamped to the previous name
  assign lenv = ($signed(11'(pend_code)) - 11'(COPY_BIAS_LO))
              + (($signed(11'(code)) - 11'(COPY_BIAS_HI)) <<< 3);
  assign copy_n = (lenv < 0 || lenv > $signed(11'(prev_len))) ? prev_len : lenv[PLW-1:0];
  assign sum = {1'b0, cur_len} + (CLW+1)'(inc);

  always_comb begin
    bare_cmd      = '0;
    bare_cmd.kind = CMD_BARE;
    bare_cmd.last = 1'b1;
    bare_cmd.ovf  = ovf_now;
    fin_cmd       = bare_cmd;
    if (held_v) begin
      fin_cmd      = held;
      fin_cmd.last = 1'b1;
      fin_cmd.ovf  = ovf_now;
    end
  end

  always_comb begin
    busy_next      = busy;
    load_next      = load;
    fin_first_next = fin_first;
    active_next    = active;
    bbuf_next      = bbuf;
    cnt_next       = cnt;
    pend_v_next    = pend_v;
    pend_code_next = pend_code;
    cur_len_next   = cur_len;
    prev_len_next  = prev_len;
    held_v_next    = held_v;
    held_next      = held;
    byte_next      = byte_r;
    first_next     = first_r;
    tend_next      = tend_r;
    q_valid        = 1'b0;
    q_cmd          = held;
    finish         = 1'b0;
    emit           = 1'b0;
    new_cmd        = '0;
    inc            = '0;

    if (!busy) begin
      if (s_tvalid) begin
        busy_next      = 1'b1;
        load_next      = 1'b1;
        byte_next      = data_byte;
        first_next     = first_of_name;
        tend_next      = table_end;
        fin_first_next = first_of_name && active && !new_archive;
        if (new_archive) begin
          active_next    = 1'b0;
          pend_v_next    = 1'b0;
          pend_code_next = '0;
          bbuf_next      = '0;
          cnt_next       = '0;
          cur_len_next   = '0;
          prev_len_next  = '0;
        end
      end
    end else if (fin_first) begin
      finish = 1'b1;
    end else if (load) begin
      load_next = 1'b0;
      if (first_r) begin
        active_next    = 1'b1;
        pend_v_next    = 1'b0;
        pend_code_next = '0;
        cur_len_next   = '0;
      end
      if (first_r || active) begin
        bbuf_next = (first_r ? 13'd0 : bbuf)
                  | 13'({5'd0, byte_r} << (first_r ? 4'd0 : cnt));
        cnt_next  = (first_r ? 4'd0 : cnt) + 4'd8;
      end
    end else if (active && cnt >= 4'd6) begin
      if (pend_v) begin
        if (copy_n != '0) begin
          emit          = 1'b1;
          inc           = copy_n;
          new_cmd.kind  = CMD_COPY;
          new_cmd.count = LEN_W'(copy_n);
          new_cmd.base  = LEN_W'(cur_len);
        end else begin
          pend_v_next = 1'b0;
          bbuf_next   = bbuf >> CODE_W;
          cnt_next    = cnt - 4'd6;
        end
      end else if (code >= CODE_COPY_MIN) begin
        pend_v_next    = 1'b1;
        pend_code_next = code;
        bbuf_next      = bbuf >> CODE_W;
        cnt_next       = cnt - 4'd6;
      end else if (code == CODE_END) begin
        finish = 1'b1;
      end else begin
        emit         = 1'b1;
        inc          = PLW'(1);
        new_cmd.kind = CMD_CHAR;
        new_cmd.ch   = alpha_char(code);
        new_cmd.base = LEN_W'(cur_len);
      end
    end else if (tend_r && active) begin
      finish = 1'b1;
    end else begin
      // step done: release the held command
      if (held_v) begin
        q_valid = 1'b1;
        if (q_ready) begin
          held_v_next = 1'b0;
          busy_next   = 1'b0;
        end
      end else begin
        busy_next = 1'b0;
      end
    end

    // a command is held back until it is known whether the name ends after it
    if (emit) begin
      q_valid = held_v;
      if (!held_v || q_ready) begin
        held_next    = new_cmd;
        held_v_next  = 1'b1;
        pend_v_next  = 1'b0;
        bbuf_next    = bbuf >> CODE_W;
        cnt_next     = cnt - 4'd6;
        cur_len_next = (sum > NAME_MAX + 1) ? CLW'(NAME_MAX + 1) : sum[CLW-1:0];
      end
    end

    if (finish) begin
      q_valid = 1'b1;
      q_cmd   = fin_cmd;
      if (q_ready) begin
        fin_first_next = 1'b0;
        held_v_next    = 1'b0;
        prev_len_next  = ovf_now ? PLW'(NAME_MAX) : cur_len[PLW-1:0];
        active_next    = 1'b0;
        pend_v_next    = 1'b0;
        pend_code_next = '0;
        bbuf_next      = '0;
        cnt_next       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      load      <= 1'b0;
      fin_first <= 1'b0;
      active    <= 1'b0;
      bbuf      <= '0;
      cnt       <= '0;
      pend_v    <= 1'b0;
      cur_len   <= '0;
      prev_len  <= '0;
      held_v    <= 1'b0;
    end else begin
      busy      <= busy_next;
      load      <= load_next;
      fin_first <= fin_first_next;
      active    <= active_next;
      bbuf      <= bbuf_next;
      cnt       <= cnt_next;
      pend_v    <= pend_v_next;
      cur_len   <= cur_len_next;
      prev_len  <= prev_len_next;
      held_v    <= held_v_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_code <= pend_code_next;
    held      <= held_next;
    byte_r    <= byte_next;
    first_r   <= first_next;
    tend_r    <= tend_next;
  end

  a_prev_len_range: assert property (@(posedge clk) disable iff (rst)
    prev_len <= NAME_MAX)
    else $error("previous name length above limit");

  a_held_only_busy: assert property (@(posedge clk) disable iff (rst)
    held_v |-> busy)
    else $error("held command outside of a byte step");

endmodule

>>> hdl/pnd_queue.sv
// pnd_queue: short command queue between front end and back end
// depends on pnd_pkg for the command type and depth
module pnd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pnd_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output pnd_pkg::cmd_t out_cmd
);
  import pnd_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          push, pop;

  assign in_ready  = (fill != CW'(QDEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(QDEPTH))
    else $error("queue fill above depth");

endmodule

>>> hdl/pnd_back.sv
// pnd_back: executes commands, keeps the two name banks and drives the result register
// copies read the previous bank one character at a time while writing the current bank
// depends on pnd_pkg
module pnd_back #(
  parameter int NAME_MAX = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  pnd_pkg::cmd_t q_cmd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [6:0]    character,
  output logic          has_char,
  output logic          end_of_name,
  output logic          overflow
);
  import pnd_pkg::*;

  localparam int IW = $clog2(NAME_MAX);
  localparam int AW = IW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [CHAR_W-1:0] store [2**AW];
  logic [CHAR_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr, rd_addr_next;

  logic [1:0]        state, state_next;
  logic              bank, bank_next;
  cmd_t              cmd_r, cmd_next;
  logic [LEN_W-1:0]  idx, idx_next;

  logic              out_free;
  logic              emit_v;
  logic [CHAR_W-1:0] emit_ch;
  logic              emit_has, emit_end, emit_ovf;
  logic              m_tvalid_next;

  logic              we;
  logic [LEN_W:0]    wpos;
  logic [CHAR_W-1:0] wd;
  logic [LEN_W-1:0]  idx_inc;
  logic              copy_done;

  assign out_free  = !m_tvalid || m_tready;
  assign idx_inc   = idx + 1'b1;
  assign copy_done = (idx_inc == cmd_r.count);

  always_comb begin
    state_next   = state;
    bank_next    = bank;
    cmd_next     = cmd_r;
    idx_next     = idx;
    rd_addr_next = rd_addr;
    q_ready      = 1'b0;
    emit_v       = 1'b0;
    emit_ch      = '0;
    emit_has     = 1'b0;
    emit_end     = 1'b0;
    emit_ovf     = 1'b0;
    we           = 1'b0;
    wpos         = {1'b0, q_cmd.base};
    wd           = q_cmd.ch;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_CHAR: begin
              if (out_free) begin
                q_ready  = 1'b1;
                emit_v   = 1'b1;
                emit_ch  = q_cmd.ch;
                emit_has = 1'b1;
                emit_end = q_cmd.last;
                emit_ovf = q_cmd.last && q_cmd.ovf;
                we       = 1'b1;
                if (q_cmd.last) begin
                  bank_next = !bank;
                end
              end
            end
            CMD_BARE: begin
              if (out_free) begin
                q_ready   = 1'b1;
                emit_v    = 1'b1;
                emit_end  = 1'b1;
                emit_ovf  = q_cmd.ovf;
                bank_next = !bank;
              end
            end
            CMD_COPY: begin
              q_ready      = 1'b1;
              cmd_next     = q_cmd;
              idx_next     = '0;
              rd_addr_next = {bank, IW'(0)};
              state_next   = ST_WAIT;
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end
      ST_WAIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        wpos = {1'b0, cmd_r.base} + {1'b0, idx};
        wd   = rd_data;
        if (out_free) begin
          emit_v   = 1'b1;
          emit_ch  = rd_data;
          emit_has = 1'b1;
          emit_end = cmd_r.last && copy_done;
          emit_ovf = cmd_r.last && copy_done && cmd_r.ovf;
          we       = 1'b1;
          idx_next = idx_inc;
          if (copy_done) begin
            state_next = ST_IDLE;
            if (cmd_r.last) begin
              bank_next = !bank;
            end
          end else begin
            rd_addr_next = {bank, idx_inc[IW-1:0]};
            state_next   = ST_WAIT;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // characters past the limit are emitted but not stored
    if (wpos >= (LEN_W+1)'(NAME_MAX)) begin
      we = 1'b0;
    end

    m_tvalid_next = m_tvalid;
    if (emit_v) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[{!bank, wpos[IW-1:0]}] <= wd;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      bank     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      bank     <= bank_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_next;
    idx     <= idx_next;
    rd_addr <= rd_addr_next;
    if (emit_v) begin
      character   <= emit_ch;
      has_char    <= emit_has;
      end_of_name <= emit_end;
      overflow    <= emit_ovf;
    end
  end

  a_copy_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && q_valid && q_cmd.kind == CMD_COPY) |-> (q_cmd.count != '0))
    else $error("copy command with zero length");

  a_copy_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_WAIT) |-> (idx < cmd_r.count))
    else $error("copy index past copy length");

endmodule

>>> hdl/packed_name_decoder.sv
// packed_name_decoder: top level of the packed name table decoder
// instantiates pnd_front, pnd_queue and pnd_back; depends on pnd_pkg
//
// usage:
//   slave side takes one table byte per word: s_tdata is the byte, s_tlast
//   marks the last byte of the table, s_tuser carries first_of_name and
//   new_archive. master side gives one result per word: a character with
//   has_char, end_of_name on tlast, overflow on the end word.
//   a byte is taken in steps: accept, the end of a name cut by a restart,
//   load, one step per 6-bit code (at most two per byte), a name end at
//   the table end and the release of the last queued command; a step that
//   hands over a command waits while the queue is full. a copy command
//   emits its characters through ST_WAIT and ST_EMIT in turn, as the name
//   store has a registered read port; a plain character or end word is
//   emitted from ST_IDLE. front and back run apart through a 4-entry
//   command queue, so bytes keep flowing while a copy drains.
//   reset clears all control state and makes the previous name empty; the
//   name store itself is not cleared. when m_tready is low the result
//   register holds, the back end stops, the queue fills and s_tready then
//   drops once the front end has a command it cannot hand over.
module packed_name_decoder #(
  parameter int NAME_MAX = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  input  logic [1:0] s_tuser,   // [0] first_of_name, [1] new_archive
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] character, [7] zero
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] has_char, [1] overflow
);
  import pnd_pkg::*;

  logic       f_valid, f_ready;
  cmd_t       f_cmd;
  logic       b_valid, b_ready;
  cmd_t       b_cmd;
  logic [6:0] character;
  logic       has_char, end_of_name, overflow;

  pnd_front #(.NAME_MAX(NAME_MAX)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .data_byte     (s_tdata),
    .first_of_name (s_tuser[0]),
    .table_end     (s_tlast),
    .new_archive   (s_tuser[1]),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_cmd         (f_cmd)
  );

  pnd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_cmd   (b_cmd)
  );

  pnd_back #(.NAME_MAX(NAME_MAX)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (b_valid),
    .q_ready     (b_ready),
    .q_cmd       (b_cmd),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .character   (character),
    .has_char    (has_char),
    .end_of_name (end_of_name),
    .overflow    (overflow)
  );

  assign m_tdata = {1'b0, character};
  assign m_tlast = end_of_name;
  assign m_tuser = {overflow, has_char};

endmodule

>>> verif/tb_packed_name_decoder.sv
// tb_packed_name_decoder: self-checking testbench for the packed name table decoder
// drives table bytes on the slave stream, predicts every result word and checks the master stream
// depends on pnd_pkg and packed_name_decoder
module tb_packed_name_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import pnd_pkg::*;

  localparam int NAME_MAX = 63;
  localparam int HOLD_CYCLES = 1000;
  localparam int PHASE_BYTES = 76;
  localparam int DRAIN_CYCLES = 60;
  // characters for codes 1..47, code 1 in the top byte
  localparam logic [8*47-1:0] ALPHA = " #$()-./?0123456789_abcdefghijklmnopqrstuvwxyz~";

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       tend;
    logic       arc;
  } tbl_byte_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       has;
    logic       eon;
    logic       ovf;
  } name_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
  logic       s_tlast = 1'b0;
  logic [1:0] s_tuser = 2'd0;   // [0] first_of_name, [1] new_archive
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [6:0] character, [7] zero
  logic       m_tlast;
  logic [1:0] m_tuser;          // [0] has_char, [1] overflow

  packed_name_decoder #(.NAME_MAX(NAME_MAX)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  tbl_byte_t byte_q[$];
  tbl_byte_t cur_byte;
  name_res_t pending_results[$];
  int        code_buf[$];
  int        bytes_made = 0;
  int        n_errors = 0;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;
  bit        hold_on = 1'b0;
  int        hold_count = 0;

  // decoder state mirror
  logic [31:0] bitbuf = 0;
  int          bitcnt = 0;
  logic [5:0]  copy_code = 0;
  bit          copy_pending = 0;
  bit          in_name = 0;
  bit          bank = 0;
  int          prev_len = 0;
  int          cur_len = 0;
  logic [6:0]  name_bank [0:1][0:NAME_MAX-1];
  name_res_t   step_res[$];
  int          last_mark = -1;

  function automatic void emit_char(logic [6:0] ch);
    name_res_t r;
    r = '{ch: ch, has: 1'b1, eon: 1'b0, ovf: 1'b0};
    step_res.push_back(r);
    last_mark = step_res.size() - 1;
    if (cur_len < NAME_MAX) name_bank[bank ^ 1'b1][cur_len] = ch;
    if (cur_len <= NAME_MAX) cur_len++;
  endfunction

  function automatic void close_name();
    name_res_t r;
    if (last_mark < 0) begin
      // nothing emitted for this name in this step: a bare word carries the end
      step_res.push_back('{ch: 7'd0, has: 1'b0, eon: 1'b0, ovf: 1'b0});
      last_mark = step_res.size() - 1;
    end
    r = step_res[last_mark];
    r.eon = 1'b1;
    r.ovf = (cur_len > NAME_MAX);
    step_res[last_mark] = r;
    bank = bank ^ 1'b1;
    prev_len = (cur_len > NAME_MAX) ? NAME_MAX : cur_len;
    in_name = 0;
    copy_pending = 0;
    copy_code = 0;
    bitbuf = 0;
    bitcnt = 0;
    last_mark = -1;
  endfunction

  // works out the result words caused by one accepted table byte
  function automatic void predict_byte(tbl_byte_t it);
    logic [5:0] code;
    int len;
    int n;
    int i;
    step_res.delete();
    last_mark = -1;
    if (it.arc) begin
      in_name = 0;
      copy_pending = 0;
      copy_code = 0;
      bitbuf = 0;
      bitcnt = 0;
      cur_len = 0;
      prev_len = 0;
    end
    if (it.first) begin
      if (in_name) close_name();
      in_name = 1;
      bitbuf = 0;
      bitcnt = 0;
      copy_pending = 0;
      copy_code = 0;
      cur_len = 0;
      last_mark = -1;
    end
    if (!in_name) return;
    bitbuf = (bitbuf | ({24'd0, it.data} << bitcnt[3:0])) & 32'h1FFF;
    bitcnt += 8;
    while (in_name && bitcnt >= 6) begin
      code = bitbuf[5:0];
      bitbuf = bitbuf >> 6;
      bitcnt -= 6;
      if (copy_pending) begin
        copy_pending = 0;
        len = (int'(copy_code) - COPY_BIAS_LO) + (int'(code) - COPY_BIAS_HI) * 8;
        n = (len < 0 || len > prev_len) ? prev_len : len;
        for (i = 0; i < n; i++) emit_char(name_bank[bank][i]);
      end else if (code >= CODE_COPY_MIN) begin
        copy_code = code;
        copy_pending = 1;
      end else if (code == CODE_END) begin
        close_name();
      end else begin
        emit_char(ALPHA[8*(47-int'(code)) +: 7]);
      end
    end
    if (it.tend && in_name) close_name();
    foreach (step_res[k]) pending_results.push_back(step_res[k]);
  endfunction

  // packs code_buf lsb first into table bytes, pads with random bits
  task automatic send_name(bit arc, bit tend);
    bit bitq[$];
    tbl_byte_t b;
    int nbytes;
    int i;
    int j;
    foreach (code_buf[k])
      for (j = 0; j < 6; j++) bitq.push_back(code_buf[k][j]);
    while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom_range(1)));
    nbytes = bitq.size() / 8;
    for (i = 0; i < nbytes; i++) begin
      for (j = 0; j < 8; j++) b.data[j] = bitq[8*i+j];
      b.first = (i == 0);
      b.arc = arc && (i == 0);
      b.tend = tend && (i == nbytes - 1);
      byte_q.push_back(b);
    end
    bytes_made += nbytes;
  endtask

  task automatic random_name();
    int n_el;
    int k;
    int ending;
    bit arc;
    bit tend;
    code_buf.delete();
    arc = ($urandom_range(99) < 6);
    tend = 0;
    n_el = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 6);
    for (k = 0; k < n_el; k++) begin
      if ($urandom_range(99) < 55) begin
        code_buf.push_back($urandom_range(1, 47));
      end else begin
        code_buf.push_back($urandom_range(48, 63));
        // lengths near the previous name's size, or anything
        code_buf.push_back($urandom_range(1) ? $urandom_range(30, 34) : $urandom_range(0, 63));
      end
    end
    ending = $urandom_range(99);
    if (ending < 70) begin
      code_buf.push_back(CODE_END);
    end else if (ending < 85) begin
      tend = 1;
    end else if (ending < 92) begin
      // copy code left waiting at the table end
      code_buf.push_back($urandom_range(48, 63));
      tend = 1;
    end
    if (code_buf.size() == 0) code_buf.push_back(CODE_END);
    send_name(arc, tend);
  endtask

  task automatic random_noise();
    tbl_byte_t b;
    int n;
    int i;
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      b.data = 8'($urandom_range(255));
      b.first = ($urandom_range(99) < 25);
      b.tend = ($urandom_range(99) < 15);
      b.arc = ($urandom_range(99) < 8);
      byte_q.push_back(b);
      bytes_made++;
    end
  endtask

  // sender: one table byte per word
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_byte(cur_byte);
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_byte = byte_q.pop_front();
          s_tdata <= cur_byte.data;
          s_tlast <= cur_byte.tend;
          s_tuser <= {cur_byte.arc, cur_byte.first};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_on && hold_count < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    name_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: tdata %h tlast %b tuser %b",
                 $time, m_tdata, m_tlast, m_tuser);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.eon ||
            m_tuser !== {want.ovf, want.has}) begin
          $display("%0t: mismatch: expected char %h has %b end %b ovf %b, got tdata %h tlast %b tuser %b",
                   $time, want.ch, want.has, want.eon, want.ovf, m_tdata, m_tlast, m_tuser);
          n_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    tbl_byte_t b;
    int ph;
    int start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle byte before any name
    b = '{data: 8'hA5, first: 1'b0, tend: 1'b0, arc: 1'b0};
    byte_q.push_back(b);
    // extreme character codes, end after a character
    code_buf = '{1, 47, 20, CODE_END};
    send_name(0, 0);
    // whole-name copies grow the previous name: 3, 9, 27, then 81 which overflows
    code_buf = '{CODE_COPY_MIN, 0, CODE_COPY_MIN, 0, 63, 63, CODE_END};
    send_name(0, 0);
    code_buf = '{CODE_COPY_MIN, 0, CODE_COPY_MIN, 0, CODE_COPY_MIN, 0, CODE_END};
    send_name(0, 0);
    // ends at the table end with a copy code still waiting
    code_buf = '{CODE_COPY_MIN, 0, CODE_COPY_MIN, 0, CODE_COPY_MIN, 0, 5, 49};
    send_name(0, 1);
    // exact prefix of two, left open and cut by a restart
    code_buf = '{58, 32};
    send_name(0, 0);
    // zero-length copy left open, then abandoned by a new archive
    code_buf = '{56, 32};
    send_name(0, 0);
    code_buf = '{CODE_COPY_MIN, 0, CODE_END};
    send_name(1, 0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 82; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 82; end
        default: begin snd_idle_pct = 31; rcv_stall_pct = 31; end
      endcase
      start = bytes_made;
      while (bytes_made - start < PHASE_BYTES) begin
        if ($urandom_range(99) < 85) random_name();
        else random_noise();
      end
      if (ph == 0) hold_on = 1'b1;
      while (byte_q.size() != 0 || s_tvalid || pending_results.size() != 0)
        @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("tb_packed_name_decoder: clean");
    end else begin
      $display("tb_packed_name_decoder: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_packed_name_decoder: errors");
    $finish;
  end

endmodule
